// ===== rtl/oflbp_pkg.sv =====
package oflbp_pkg;

	localparam int ACTION_W = 1;
	localparam int INDEX_W = 9;
	localparam int COUNT_W = 10;
	localparam int STATUS_W = 2;
	localparam int BLOCK_COUNT_RESET = 512;

	localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_FREE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

	localparam logic REG_BLOCK_COUNT = 1'b0;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0] granted_index;
		logic [COUNT_W-1:0] free_count;
		logic all_free;
		logic none_free;
	} rsp_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_DECIDE,
		S_ALLOC_RD,
		S_WALK,
		S_LINK,
		S_RESULT
	} state_t;

endpackage

// ===== rtl/oflbp_ram.sv =====
module oflbp_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] ram_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		rdata_q <= ram_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ordered_free_list_block_pool.sv =====
// Allocate: S_DECIDE, S_ALLOC_RD, then S_RESULT registers the result; an exhausted pool skips
// S_ALLOC_RD. Free: S_DECIDE to S_RESULT when rejected at once or placed ahead of the head; else
// S_WALK over the free entries between head and block, S_LINK, S_RESULT (no S_LINK on a double free).
// One item is in flight; the next transfer is taken the cycle after its result is registered.
// After reset and after every block_count write, a clearing pass over all MAX_BLOCKS entries
// rebuilds the link memory while input transfers are stalled; the register port stays open.
module ordered_free_list_block_pool #(
	parameter int MAX_BLOCKS = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  oflbp_pkg::req_t      req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output oflbp_pkg::rsp_t      rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	import oflbp_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam logic [LW-1:0] END_CODE = LW'(MAX_BLOCKS);
	localparam int BC_RESET = (MAX_BLOCKS < BLOCK_COUNT_RESET) ? MAX_BLOCKS : BLOCK_COUNT_RESET;
	localparam logic [IW-1:0] SWEEP_LAST = IW'(MAX_BLOCKS - 1);

	state_t state_q, state_d;
	logic [LW-1:0] head_q, head_d;
	logic [LW-1:0] total_q, total_d;
	logic [LW-1:0] bc_q, bc_d;
	logic [IW-1:0] sweep_q, sweep_d;
	logic [LW-1:0] pre_q, pre_d;
	logic [LW-1:0] nxt_q, nxt_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [LW-1:0] granted_q, granted_d;
	logic [ACTION_W-1:0] act_q;
	logic [INDEX_W-1:0] blk_q;
	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_load;

	logic mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [LW-1:0] mem_wdata, mem_rdata;

	logic cfg_write;
	logic [31:0] cfg_clamp;
	logic [LW-1:0] sweep_inc, sweep_link;
	logic [LW-1:0] rd_link, blk_l;
	logic head_end, blk_in_range;

	oflbp_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? 32'(bc_q) : 32'd0;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);

	always_comb begin
		priority if (pwdata[COUNT_W-1:0] == '0) begin
			cfg_clamp = 32'd1;
		end else if (32'(pwdata[COUNT_W-1:0]) > 32'(MAX_BLOCKS)) begin
			cfg_clamp = 32'(MAX_BLOCKS);
		end else begin
			cfg_clamp = 32'(pwdata[COUNT_W-1:0]);
		end
	end

	assign sweep_inc = LW'(sweep_q) + LW'(1);
	assign sweep_link = (sweep_inc < bc_q) ? sweep_inc : END_CODE;
	assign rd_link = (mem_rdata >= END_CODE) ? END_CODE : mem_rdata;
	assign blk_l = LW'(blk_q);
	assign head_end = (head_q >= END_CODE);
	assign blk_in_range = (32'(blk_q) < 32'(bc_q));

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		rsp_d.status = status_q;
		rsp_d.granted_index = INDEX_W'(granted_q);
		rsp_d.free_count = COUNT_W'(total_q);
		rsp_d.all_free = (total_q == bc_q);
		rsp_d.none_free = (total_q == '0);
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		total_d = total_q;
		bc_d = bc_q;
		sweep_d = sweep_q;
		pre_d = pre_q;
		nxt_d = nxt_q;
		status_d = status_q;
		granted_d = granted_q;
		mem_we = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = sweep_link;
		mem_raddr = IW'(head_q);
		rsp_load = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				mem_we = 1'b1;
				if (sweep_q == SWEEP_LAST) begin
					state_d = S_IDLE;
				end else begin
					sweep_d = sweep_q + IW'(1);
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				granted_d = '0;
				if (act_q == ACT_ALLOC) begin
					if (head_end || total_q == '0) begin
						status_d = STATUS_EXHAUSTED;
						state_d = S_RESULT;
					end else begin
						status_d = STATUS_OK;
						granted_d = head_q;
						state_d = S_ALLOC_RD;
					end
				end else begin
					priority if (!blk_in_range || blk_l == head_q) begin
						status_d = STATUS_BAD_FREE;
						state_d = S_RESULT;
					end else if (head_end || blk_l < head_q) begin
						mem_we = 1'b1;
						mem_waddr = IW'(blk_l);
						mem_wdata = head_q;
						head_d = blk_l;
						total_d = total_q + LW'(1);
						status_d = STATUS_OK;
						state_d = S_RESULT;
					end else begin
						pre_d = head_q;
						state_d = S_WALK;
					end
				end
			end
			S_ALLOC_RD: begin
				head_d = rd_link;
				total_d = total_q - LW'(1);
				state_d = S_RESULT;
			end
			S_WALK: begin
				priority if (rd_link < blk_l) begin
					pre_d = rd_link;
					mem_raddr = IW'(rd_link);
				end else if (rd_link == blk_l) begin
					status_d = STATUS_BAD_FREE;
					state_d = S_RESULT;
				end else begin
					mem_we = 1'b1;
					mem_waddr = IW'(pre_q);
					mem_wdata = blk_l;
					nxt_d = rd_link;
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				mem_we = 1'b1;
				mem_waddr = IW'(blk_l);
				mem_wdata = nxt_q;
				total_d = total_q + LW'(1);
				status_d = STATUS_OK;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_SWEEP;
			end
		endcase
		if (cfg_write) begin
			bc_d = cfg_clamp[LW-1:0];
			total_d = cfg_clamp[LW-1:0];
			head_d = '0;
			sweep_d = '0;
			state_d = S_SWEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			head_q <= '0;
			total_q <= LW'(BC_RESET);
			bc_q <= LW'(BC_RESET);
			sweep_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			total_q <= total_d;
			bc_q <= bc_d;
			sweep_q <= sweep_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			act_q <= req.action;
			blk_q <= req.block_index;
		end
		pre_q <= pre_d;
		nxt_q <= nxt_d;
		status_q <= status_d;
		granted_q <= granted_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= bc_q)
		else $error("Free count exceeds the number of blocks.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (head_end == (total_q == '0)))
		else $error("List head and free count disagree on an empty pool.");

	assert property (@(posedge clk) disable iff (!arst_n)
		head_end || (head_q < bc_q))
		else $error("List head points past the last block.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (32'(rsp_q.granted_index) < 32'(bc_q)))
		else $error("Granted block lies outside the pool.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_ALLOC_RD) |-> (head_d == head_q || state_q == S_ALLOC_RD
			|| cfg_write))
		else $error("List head changed during an ordered walk.");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import oflbp_pkg::*;

	localparam int POOL_MAX = 512;
	localparam int POOL_END = POOL_MAX;
	localparam logic [2:0] ADDR_BLOCK_COUNT = 3'(4 * REG_BLOCK_COUNT);
	localparam logic [2:0] ADDR_UNMAPPED = 3'(4 * (REG_BLOCK_COUNT + 1));
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 173;
	localparam int DIR_ROWS = 28;
	localparam req_t NO_REQ = '0;
	localparam rsp_t NO_RSP = '0;

	typedef struct {
		bit cfg;
		logic [2:0] addr;
		logic [31:0] wdata;
		req_t item;
		bit typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	logic [COUNT_W-1:0] nxt_link [POOL_MAX];
	logic [COUNT_W-1:0] head_blk;
	logic [COUNT_W-1:0] free_num;
	logic [COUNT_W-1:0] blocks_cfg;
	bit held [POOL_MAX];

	rsp_t result_q [$];
	int fault_count = 0;
	int item_count = 0;
	int result_count = 0;
	int write_count = 0;
	int status_seen [3] = '{0, 0, 0};
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b1, '{STATUS_OK, 9'd0, 10'd511, 1'b0, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd0}, 1'b1, '{STATUS_OK, 9'd0, 10'd512, 1'b1, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd0}, 1'b1,
			'{STATUS_BAD_FREE, 9'd0, 10'd512, 1'b1, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd511}, 1'b1,
			'{STATUS_BAD_FREE, 9'd0, 10'd512, 1'b1, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b1, '{STATUS_OK, 9'd0, 10'd511, 1'b0, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b1, '{STATUS_OK, 9'd1, 10'd510, 1'b0, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd1}, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b0, NO_RSP},
		'{1'b1, ADDR_UNMAPPED, 32'd5, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd0}, 1'b0, NO_RSP},
		'{1'b1, ADDR_BLOCK_COUNT, 32'd0, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b1, '{STATUS_OK, 9'd0, 10'd0, 1'b0, 1'b1}},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b1,
			'{STATUS_EXHAUSTED, 9'd0, 10'd0, 1'b0, 1'b1}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd1}, 1'b1,
			'{STATUS_BAD_FREE, 9'd0, 10'd0, 1'b0, 1'b1}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd511}, 1'b1,
			'{STATUS_BAD_FREE, 9'd0, 10'd0, 1'b0, 1'b1}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd0}, 1'b1, '{STATUS_OK, 9'd0, 10'd1, 1'b1, 1'b0}},
		'{1'b1, ADDR_BLOCK_COUNT, 32'd2, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd0}, 1'b1,
			'{STATUS_EXHAUSTED, 9'd0, 10'd0, 1'b0, 1'b1}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd1}, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd0}, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd1}, 1'b1,
			'{STATUS_BAD_FREE, 9'd0, 10'd2, 1'b1, 1'b0}},
		'{1'b1, ADDR_BLOCK_COUNT, 32'd1023, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd300}, 1'b1,
			'{STATUS_BAD_FREE, 9'd0, 10'd512, 1'b1, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_ALLOC, 9'd511}, 1'b1,
			'{STATUS_OK, 9'd0, 10'd511, 1'b0, 1'b0}},
		'{1'b0, 3'd0, 32'd0, '{ACT_FREE, 9'd0}, 1'b0, NO_RSP}
	};

	ordered_free_list_block_pool #(
		.MAX_BLOCKS(POOL_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic void pool_rebuild(input logic [31:0] value);
		int v;
		v = int'(value[9:0]);
		if (v < 1) begin
			v = 1;
		end
		if (v > POOL_MAX) begin
			v = POOL_MAX;
		end
		for (int i = 0; i < POOL_MAX; i++) begin
			nxt_link[i] = COUNT_W'(POOL_END);
			held[i] = 1'b0;
		end
		for (int i = 0; i + 1 < v; i++) begin
			nxt_link[i] = COUNT_W'(i + 1);
		end
		blocks_cfg = COUNT_W'(v);
		head_blk = '0;
		free_num = COUNT_W'(v);
	endfunction

	// Links at or past the end code read as the end of the list.
	function automatic int link_of(input int idx);
		if (idx >= POOL_MAX || int'(nxt_link[idx]) >= POOL_MAX) begin
			return POOL_END;
		end
		return int'(nxt_link[idx]);
	endfunction

	function automatic logic [STATUS_W-1:0] pool_release(input int blk);
		int pre;
		int nxt;
		int steps;
		int hd;
		hd = int'(head_blk);
		if (blk >= int'(blocks_cfg) || blk >= POOL_MAX || hd == blk) begin
			return STATUS_BAD_FREE;
		end
		if (hd >= POOL_MAX || blk < hd) begin
			nxt_link[blk] = (hd >= POOL_MAX) ? COUNT_W'(POOL_END) : head_blk;
			head_blk = COUNT_W'(blk);
		end else begin
			pre = hd;
			nxt = link_of(pre);
			steps = 0;
			while (nxt != POOL_END && nxt < blk && steps < POOL_MAX) begin
				pre = nxt;
				nxt = link_of(pre);
				steps++;
			end
			if (nxt == blk) begin
				return STATUS_BAD_FREE;
			end
			nxt_link[pre] = COUNT_W'(blk);
			nxt_link[blk] = COUNT_W'(nxt);
		end
		free_num++;
		held[blk] = 1'b0;
		return STATUS_OK;
	endfunction

	function automatic rsp_t pool_apply(input req_t it);
		rsp_t r;
		int granted;
		r = '0;
		granted = 0;
		if (it.action == ACT_ALLOC) begin
			if (int'(head_blk) >= POOL_MAX || free_num == 0) begin
				r.status = STATUS_EXHAUSTED;
			end else begin
				granted = int'(head_blk);
				head_blk = COUNT_W'(link_of(granted));
				free_num--;
				held[granted] = 1'b1;
				r.status = STATUS_OK;
			end
		end else begin
			r.status = pool_release(int'(it.block_index));
		end
		r.granted_index = INDEX_W'(granted);
		r.free_count = free_num;
		r.all_free = (free_num == blocks_cfg);
		r.none_free = (free_num == 0);
		return r;
	endfunction

	// Frees mostly target held blocks so that the ordered insert does real work.
	function automatic req_t next_random_item(input int alloc_pct);
		req_t it;
		int roll;
		int b;
		int tries;
		it.action = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
		it.block_index = INDEX_W'($urandom_range(0, POOL_MAX - 1));
		if (it.action == ACT_FREE) begin
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				b = $urandom_range(0, int'(blocks_cfg) - 1);
				tries = 0;
				while (!held[b] && tries < 16) begin
					b = $urandom_range(0, int'(blocks_cfg) - 1);
					tries++;
				end
				it.block_index = INDEX_W'(b);
			end else if (roll < 9) begin
				it.block_index = INDEX_W'($urandom_range(0, int'(blocks_cfg) - 1));
			end
		end
		return it;
	endfunction

	task automatic send_item(input req_t it, input bit typed, input rsp_t want);
		rsp_t pred;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		pred = pool_apply(it);
		result_q.push_back(typed ? want : pred);
		item_count++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (result_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_BLOCK_COUNT) begin
			pool_rebuild(value);
		end
		write_count++;
	endtask

	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if (rsp_valid && !rsp_stall) begin
			result_count++;
			if (rsp.status < 3) begin
				status_seen[rsp.status]++;
			end
			if (result_q.size() == 0) begin
				$error("unexpected result transfer: %p", rsp);
				fault_count++;
			end else begin
				exp_r = result_q.pop_front();
				if (rsp.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp.status);
					fault_count++;
				end
				if (rsp.granted_index !== exp_r.granted_index) begin
					$error("granted_index: expected %0d, got %0d",
						exp_r.granted_index, rsp.granted_index);
					fault_count++;
				end
				if (rsp.free_count !== exp_r.free_count) begin
					$error("free_count: expected %0d, got %0d",
						exp_r.free_count, rsp.free_count);
					fault_count++;
				end
				if (rsp.all_free !== exp_r.all_free) begin
					$error("all_free: expected %0d, got %0d", exp_r.all_free, rsp.all_free);
					fault_count++;
				end
				if (rsp.none_free !== exp_r.none_free) begin
					$error("none_free: expected %0d, got %0d", exp_r.none_free, rsp.none_free);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ordered_free_list_block_pool test failed");
			$finish;
		end
	end

	initial begin
		int unsigned fixed_vals [6];
		logic [31:0] value;
		int alloc_pct;
		fixed_vals = '{32'd0, 32'd2, 32'd1023, 32'hFFFF_FC05, 32'd512, 32'd600};
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		alloc_pct = 50;
		pool_rebuild(32'(BLOCK_COUNT_RESET));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (directed_rows[r].cfg) begin
				drain();
				reg_write(directed_rows[r].addr, directed_rows[r].wdata);
			end else begin
				send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p < 6) begin
				value = fixed_vals[p];
			end else if (p < PHASES - 1) begin
				value = 32'($urandom_range(3, 64)) | ({$urandom} & 32'hFFFF_FC00);
			end else begin
				value = 32'($urandom_range(1, POOL_MAX));
			end
			drain();
			reg_write(ADDR_BLOCK_COUNT, value);
			idle_on = (p != PHASES - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0) begin
					case ($urandom_range(0, 2))
						0: alloc_pct = 15;
						1: alloc_pct = 50;
						default: alloc_pct = 85;
					endcase
				end
				if (p != PHASES - 1 && n % 100 == 0) begin
					idle_on = ($urandom_range(0, 3) != 0);
				end
				send_item(next_random_item(alloc_pct), 1'b0, NO_RSP);
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (result_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (result_q.size() != 0) begin
			$error("%0d expected results never arrived", result_q.size());
			fault_count++;
		end

		$display("%0d transfers in, %0d results checked, %0d register writes",
			item_count, result_count, write_count);
		$display("statuses seen: %0d ok, %0d exhausted, %0d bad free",
			status_seen[0], status_seen[1], status_seen[2]);
		if (fault_count == 0) begin
			$display("ordered_free_list_block_pool test passed");
		end else begin
			$display("ordered_free_list_block_pool test failed");
		end
		$finish;
	end

endmodule
